// ----- hdl/lbs_pkg.sv -----
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types and constants for the bounded LIFO stack.
// ----------------------------------------------------------------------------
`default_nettype none

package lbs_pkg;

  localparam int COUNT_W  = 5;
  localparam int CAP_W    = 5;
  localparam int STATUS_W = 2;
  localparam int LEVEL_W  = 5;

  // capacity register value of zero selects this size
  localparam int DEFAULT_CAP = 5;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_t;

  // shift command broadcast to every cell of the chain
  typedef struct packed {
    logic push;   // shift toward the bottom, new element enters the top cell
    logic pop;    // shift toward the top, top element leaves
  } shift_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/lbs_cell.sv -----
// ----------------------------------------------------------------------------
// lbs_cell
// One stack entry; takes its neighbor's value on push or pop.
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_cell #(
  parameter int WIDTH = 32
) (
  input  wire                     clk,
  input  wire lbs_pkg::shift_ctl_t ctl,
  input  wire logic [WIDTH-1:0]   from_up,
  input  wire logic [WIDTH-1:0]   from_down,
  output logic      [WIDTH-1:0]   q
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      q <= from_up;
    end else if (ctl.pop) begin
      q <= from_down;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bounded_lifo_stack.sv -----
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// Bounded LIFO stack built as a shifting row of cells, top element in cell 0.
// ----------------------------------------------------------------------------
// Timing: a request's first result is registered, out in the cycle after it is
//   taken; the further elements of a pop run follow on consecutive cycles.
// Throughput: push and peek take one request per cycle while not busy; a pop
//   of n elements gives one element per cycle and holds busy high meanwhile.
// Reset (rst, synchronous): fill level, push run tracking and the sequencer
//   are cleared and capacity returns to 16; cell contents are left as they are.
`default_nettype none

module bounded_lifo_stack #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // request channel
  input  wire                                 start,
  output logic                                busy,
  input  wire logic [1:0]                     op,
  input  wire logic [lbs_pkg::COUNT_W-1:0]    count,
  input  wire logic signed [WIDTH-1:0]        value,
  // capacity register
  input  wire                                 wr_en,
  input  wire logic [lbs_pkg::CAP_W-1:0]      wr_data,
  // result channel
  output logic                                done,
  output logic signed [WIDTH-1:0]             value_res,
  output logic [lbs_pkg::STATUS_W-1:0]        status,
  output logic                                last,
  output logic [lbs_pkg::LEVEL_W-1:0]         fill_level,
  output logic                                full_res,
  output logic                                empty_res
);

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int SUM_W  = ((FILL_W > lbs_pkg::COUNT_W) ? FILL_W : lbs_pkg::COUNT_W) + 1;
  localparam int DEF_CAP = (lbs_pkg::DEFAULT_CAP < DEPTH) ? lbs_pkg::DEFAULT_CAP : DEPTH;
  localparam logic [FILL_W-1:0] DEPTH_F   = FILL_W'(DEPTH);
  localparam logic [FILL_W-1:0] DEF_CAP_F = FILL_W'(DEF_CAP);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [lbs_pkg::CAP_W-1:0]   capacity;
  logic [FILL_W-1:0]           fill, fill_next;
  logic [lbs_pkg::COUNT_W-1:0] run_left, run_left_next;
  logic                        run_rejected, run_rejected_next;
  logic [lbs_pkg::COUNT_W-1:0] pop_left, pop_left_next;
  lbs_pkg::state_t             state, state_next;

  logic                        done_next;
  logic [WIDTH-1:0]            value_res_next;
  lbs_pkg::status_t            status_next;
  logic                        last_next;

  // --------------------------------------------------------------------------
  // Cell chain: push shifts every cell one place down, pop one place up.
  // Entries at or above the fill level may hold stale data; they are never
  // read before a push overwrites them.
  // --------------------------------------------------------------------------
  lbs_pkg::shift_ctl_t ctl;
  logic [WIDTH-1:0]    cell_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] up_d;
    logic [WIDTH-1:0] down_d;

    if (i == 0) begin : g_top
      assign up_d = value;
    end else begin : g_mid
      assign up_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign down_d = cell_q[i];
    end else begin : g_above
      assign down_d = cell_q[i+1];
    end

    lbs_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .from_up   (up_d),
      .from_down (down_d),
      .q         (cell_q[i])
    );
  end

  // --------------------------------------------------------------------------
  // Effective capacity: zero selects the default size, above DEPTH saturates.
  // --------------------------------------------------------------------------
  logic [FILL_W-1:0] eff_cap;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = DEF_CAP_F;
    end else if (int'(capacity) > DEPTH) begin
      eff_cap = DEPTH_F;
    end else begin
      eff_cap = FILL_W'(capacity);
    end
  end

  // count of zero is taken as one
  logic [lbs_pkg::COUNT_W-1:0] cnt_eff;
  assign cnt_eff = (count == '0) ? lbs_pkg::COUNT_W'(1) : count;

  // run does not fit: fill + count > capacity (also covers fill above capacity)
  logic run_too_big;
  logic pop_too_big;
  assign run_too_big = (SUM_W'(fill) + SUM_W'(cnt_eff)) > SUM_W'(eff_cap);
  assign pop_too_big = SUM_W'(cnt_eff) > SUM_W'(fill);

  // push run bookkeeping for the current request
  logic [lbs_pkg::COUNT_W-1:0] push_left;
  logic                        push_rej;

  assign busy = (state == lbs_pkg::ST_POP);

  // --------------------------------------------------------------------------
  // Sequencer: next state, shift command and result fields
  // --------------------------------------------------------------------------
  always_comb begin
    state_next        = state;
    fill_next         = fill;
    run_left_next     = run_left;
    run_rejected_next = run_rejected;
    pop_left_next     = pop_left;
    ctl               = '0;
    done_next         = 1'b0;
    value_res_next    = '0;
    status_next       = lbs_pkg::STAT_OK;
    last_next         = 1'b0;
    push_left         = run_left;
    push_rej          = run_rejected;

    case (state)
      lbs_pkg::ST_IDLE: begin
        if (start) begin
          case (lbs_pkg::op_t'(op))
            lbs_pkg::OP_PUSH: begin
              // space is checked only on the first item of a run
              if (run_left == '0) begin
                push_left = cnt_eff;
                push_rej  = run_too_big;
              end
              if (!push_rej && fill < DEPTH_F) begin
                ctl.push  = 1'b1;
                fill_next = fill + FILL_W'(1);
              end
              push_left     = push_left - lbs_pkg::COUNT_W'(1);
              run_left_next = push_left;
              if (push_left == '0) begin
                done_next         = 1'b1;
                status_next       = push_rej ? lbs_pkg::STAT_OVERFLOW : lbs_pkg::STAT_OK;
                last_next         = 1'b1;
                run_rejected_next = 1'b0;
              end else begin
                run_rejected_next = push_rej;
              end
            end
            lbs_pkg::OP_POP: begin
              // an open push run is abandoned
              run_left_next     = '0;
              run_rejected_next = 1'b0;
              done_next         = 1'b1;
              if (pop_too_big) begin
                status_next = lbs_pkg::STAT_UNDERFLOW;
                last_next   = 1'b1;
              end else begin
                // first element leaves right away, the rest one per cycle
                ctl.pop        = 1'b1;
                fill_next      = fill - FILL_W'(1);
                value_res_next = cell_q[0];
                last_next      = (cnt_eff == lbs_pkg::COUNT_W'(1));
                pop_left_next  = cnt_eff - lbs_pkg::COUNT_W'(1);
                if (cnt_eff != lbs_pkg::COUNT_W'(1)) begin
                  state_next = lbs_pkg::ST_POP;
                end
              end
            end
            lbs_pkg::OP_PEEK: begin
              run_left_next     = '0;
              run_rejected_next = 1'b0;
              done_next         = 1'b1;
              last_next         = 1'b1;
              if (fill == '0) begin
                status_next = lbs_pkg::STAT_EMPTY;
              end else begin
                value_res_next = cell_q[0];
              end
            end
            default: begin
              // unused selector: no result, no state change
            end
          endcase
        end
      end
      lbs_pkg::ST_POP: begin
        ctl.pop        = 1'b1;
        fill_next      = fill - FILL_W'(1);
        value_res_next = cell_q[0];
        done_next      = 1'b1;
        last_next      = (pop_left == lbs_pkg::COUNT_W'(1));
        pop_left_next  = pop_left - lbs_pkg::COUNT_W'(1);
        if (pop_left == lbs_pkg::COUNT_W'(1)) begin
          state_next = lbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lbs_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lbs_pkg::ST_IDLE;
      fill         <= '0;
      run_left     <= '0;
      run_rejected <= 1'b0;
      pop_left     <= '0;
      capacity     <= lbs_pkg::CAP_W'(16);
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      fill         <= fill_next;
      run_left     <= run_left_next;
      run_rejected <= run_rejected_next;
      pop_left     <= pop_left_next;
      done         <= done_next;
      if (wr_en) begin
        capacity <= wr_data;
      end
    end
  end

  // result payload, flags reflect the fill level after this result
  always_ff @(posedge clk) begin
    value_res  <= value_res_next;
    status     <= status_next;
    last       <= last_next;
    fill_level <= lbs_pkg::LEVEL_W'(fill_next);
    full_res   <= (fill_next >= eff_cap);
    empty_res  <= (fill_next == '0);
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= DEPTH_F)
    else $error("fill level beyond built depth");

  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    (state == lbs_pkg::ST_POP) |=> (fill == $past(fill) - FILL_W'(1)))
    else $error("pop run cycle did not remove exactly one element");

  a_pop_emits: assert property (@(posedge clk) disable iff (rst)
    (state == lbs_pkg::ST_POP) |=> (done && status == lbs_pkg::STAT_OK))
    else $error("pop run cycle gave no element");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (done && status != lbs_pkg::STAT_OK) |-> (last && value_res == '0))
    else $error("error result not final or carries data");

endmodule

`default_nettype wire

// ----- test/tb_bounded_lifo_stack.sv -----
// ----------------------------------------------------------------------------
// tb_bounded_lifo_stack
// Self-checking bench for the bounded LIFO stack: a shadow stack predicts
// every result of each accepted request, and a monitor compares the done
// strobes field by field against those predictions in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bounded_lifo_stack;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  localparam int WIDTH       = 32;
  localparam int QUIET_LIMIT = 1000;   // cycles with no traffic before giving up

  // one expected result of the stack
  typedef struct {
    logic signed [WIDTH-1:0]     data;
    lbs_pkg::status_t            stat;
    logic                        fin;
    logic [lbs_pkg::LEVEL_W-1:0] level;
    logic                        full;
    logic                        empty;
  } stack_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic [1:0]                   op = lbs_pkg::OP_NONE;
  logic [lbs_pkg::COUNT_W-1:0]  count = '0;
  logic signed [WIDTH-1:0]      value = '0;
  logic                         wr_en = 1'b0;
  logic [lbs_pkg::CAP_W-1:0]    wr_data = '0;
  logic                         done;
  logic signed [WIDTH-1:0]      value_res;
  logic [lbs_pkg::STATUS_W-1:0] status;
  logic                         last;
  logic [lbs_pkg::LEVEL_W-1:0]  fill_level;
  logic                         full_res;
  logic                         empty_res;

  // shadow copy of the stack
  logic [WIDTH-1:0]             stack_mem [DEPTH];
  int unsigned                  stack_level = 0;
  int unsigned                  run_remaining = 0;
  bit                           run_dropped = 1'b0;
  logic [lbs_pkg::CAP_W-1:0]    capacity_shadow = 5'd16;

  stack_result_t                expected_results[$];
  int                           mismatches = 0;
  int                           quiet_cycles = 0;
  int                           items_sent = 0;
  int                           burst_left = 0;
  bit                           gap_en = 1'b1;

  always #10 clk = ~clk;

  bounded_lifo_stack #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .count      (count),
    .value      (value),
    .wr_en      (wr_en),
    .wr_data    (wr_data),
    .done       (done),
    .value_res  (value_res),
    .status     (status),
    .last       (last),
    .fill_level (fill_level),
    .full_res   (full_res),
    .empty_res  (empty_res)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // capacity in force: zero picks the default size, oversize clamps to DEPTH
  function automatic int unsigned eff_capacity();
    int unsigned c;
    c = capacity_shadow;
    if (c == 0) c = (lbs_pkg::DEFAULT_CAP < DEPTH) ? lbs_pkg::DEFAULT_CAP : DEPTH;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  // level and flags are taken after the state change that the result reports
  function automatic void queue_result(logic [WIDTH-1:0] d, lbs_pkg::status_t st,
                                       logic fin);
    stack_result_t r;
    r.data  = d;
    r.stat  = st;
    r.fin   = fin;
    r.level = stack_level[lbs_pkg::LEVEL_W-1:0];
    r.full  = stack_level >= eff_capacity();
    r.empty = stack_level == 0;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_stack_op(lbs_pkg::op_t o,
                                           logic [lbs_pkg::COUNT_W-1:0] cnt,
                                           logic [WIDTH-1:0] v);
    int unsigned n;
    n = (cnt == 0) ? 1 : cnt;
    case (o)
      lbs_pkg::OP_PUSH: begin
        // room for the whole run is judged on its first request only
        if (run_remaining == 0) begin
          run_remaining = n;
          run_dropped = (stack_level > eff_capacity()) ||
                        (n > eff_capacity() - stack_level);
        end
        if (!run_dropped && stack_level < DEPTH) begin
          stack_mem[stack_level] = v;
          stack_level++;
        end
        run_remaining--;
        if (run_remaining == 0) begin
          queue_result('0, run_dropped ? lbs_pkg::STAT_OVERFLOW : lbs_pkg::STAT_OK, 1'b1);
          run_dropped = 1'b0;
        end
      end
      lbs_pkg::OP_POP: begin
        // any pop or peek abandons an open push run
        run_remaining = 0;
        run_dropped = 1'b0;
        if (n > stack_level) begin
          queue_result('0, lbs_pkg::STAT_UNDERFLOW, 1'b1);
        end else begin
          while (n > 0) begin
            stack_level--;
            n--;
            queue_result(stack_mem[stack_level], lbs_pkg::STAT_OK, n == 0);
          end
        end
      end
      lbs_pkg::OP_PEEK: begin
        run_remaining = 0;
        run_dropped = 1'b0;
        if (stack_level == 0) queue_result('0, lbs_pkg::STAT_EMPTY, 1'b1);
        else queue_result(stack_mem[stack_level-1], lbs_pkg::STAT_OK, 1'b1);
      end
      default: ;  // unused selector: no result, no state change
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: results are checked before new requests are predicted, so the
  // queue order never depends on process scheduling.
  // --------------------------------------------------------------------------
  function automatic void check_result();
    stack_result_t e;
    if (expected_results.size() == 0) begin
      $error("unexpected result: value_res=%0d status=%0d", value_res, status);
      mismatches++;
      return;
    end
    e = expected_results.pop_front();
    if (value_res !== e.data) begin
      $error("value_res: expected %0d, got %0d", e.data, value_res);
      mismatches++;
    end
    if (status !== e.stat) begin
      $error("status: expected %0d, got %0d", e.stat, status);
      mismatches++;
    end
    if (last !== e.fin) begin
      $error("last: expected %0d, got %0d", e.fin, last);
      mismatches++;
    end
    if (fill_level !== e.level) begin
      $error("fill_level: expected %0d, got %0d", e.level, fill_level);
      mismatches++;
    end
    if (full_res !== e.full) begin
      $error("full_res: expected %0d, got %0d", e.full, full_res);
      mismatches++;
    end
    if (empty_res !== e.empty) begin
      $error("empty_res: expected %0d, got %0d", e.empty, empty_res);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) check_result();
      if (wr_en) capacity_shadow = wr_data;
      if (start && !busy) predict_stack_op(lbs_pkg::op_t'(op), count, value);
      if ((start && !busy) || done === 1'b1 || wr_en) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // watchdog: a hung handshake ends the run
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers: inputs change on the falling edge only
  // --------------------------------------------------------------------------
  function automatic logic [WIDTH-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // start low while idling; the request fields carry junk meanwhile
  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
      op = $urandom;
      count = $urandom;
      value = $urandom;
      wr_data = $urandom;
    end
  endtask

  // one request; returns at the edge that accepts it, start left high
  task automatic send_request(lbs_pkg::op_t o, logic [lbs_pkg::COUNT_W-1:0] c,
                              logic [WIDTH-1:0] v);
    if (gap_en) begin
      if (burst_left == 0) begin
        idle_cycles($urandom_range(1, 6));
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
    end
    @(negedge clk);
    start = 1'b1;
    op = o;
    count = c;
    value = v;
    do @(posedge clk); while (busy);
    if (o != lbs_pkg::OP_NONE) items_sent++;
  endtask

  // wait for every pending result, then let the last request settle
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_capacity(logic [lbs_pkg::CAP_W-1:0] c);
    drain();
    wr_en = 1'b1;
    wr_data = c;
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // peek and pops on a stack that has never held anything
  task automatic test_empty_stack();
    send_request(lbs_pkg::OP_PEEK, 5'd0, 32'h1234_5678);
    send_request(lbs_pkg::OP_POP, 5'd1, '0);
    send_request(lbs_pkg::OP_POP, 5'd0, '0);   // count zero means one
  endtask

  // a single-entry stack fills on one push and rejects the next
  task automatic test_small_capacity();
    write_capacity(5'd1);
    send_request(lbs_pkg::OP_PUSH, 5'd1, 32'h7fff_ffff);
    send_request(lbs_pkg::OP_PUSH, 5'd1, '0);
    send_request(lbs_pkg::OP_POP, 5'd0, '0);
  endtask

  // capacity zero selects the default size
  task automatic test_default_capacity();
    write_capacity(5'd0);
    send_request(lbs_pkg::OP_PUSH, 5'd3, 32'h8000_0000);
    send_request(lbs_pkg::OP_NONE, 5'd7, 32'hdead_beef);   // ignored, run stays open
    send_request(lbs_pkg::OP_PUSH, 5'd9, 32'hffff_ffff);
    send_request(lbs_pkg::OP_PUSH, 5'd1, '0);
    send_request(lbs_pkg::OP_PEEK, 5'd4, '0);
    send_request(lbs_pkg::OP_PUSH, 5'd2, 32'h0000_0001);
    send_request(lbs_pkg::OP_PUSH, 5'd31, 32'h5555_aaaa);  // later count field ignored
    send_request(lbs_pkg::OP_PUSH, 5'd1, 32'h0f0f_0f0f);   // no room left
  endtask

  // capacity dropped under the fill level: nothing lost, stack reads as full
  task automatic test_shrink_capacity();
    write_capacity(5'd2);
    send_request(lbs_pkg::OP_PEEK, 5'd0, '0);
    send_request(lbs_pkg::OP_PUSH, 5'd1, 32'h1111_1111);
    send_request(lbs_pkg::OP_POP, 5'd4, '0);
    send_request(lbs_pkg::OP_PUSH, 5'd1, 32'h2222_2222);
  endtask

  // a pop mid-run abandons the run but keeps what it already pushed
  task automatic test_abandoned_run();
    write_capacity(5'd31);
    send_request(lbs_pkg::OP_PUSH, 5'd3, 32'h3333_3333);
    send_request(lbs_pkg::OP_POP, 5'd2, '0);
    send_request(lbs_pkg::OP_POP, 5'd5, '0);
    send_request(lbs_pkg::OP_POP, 5'd1, '0);
  endtask

  // phases of mostly well-formed traffic at several capacities
  task automatic test_random_traffic();
    logic [lbs_pkg::CAP_W-1:0] caps [8];
    int                        phase_base;
    int                        pick;
    int                        room;
    int                        n;
    int                        sent;
    int                        cut;
    caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd9, 5'd17, 5'd3, 5'd16};
    for (int p = 0; p < 8; p++) begin
      write_capacity(p == 7 ? 5'($urandom_range(0, 31)) : caps[p]);
      gap_en = (p % 3) != 2;
      phase_base = items_sent;
      while (items_sent - phase_base < 48) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          // push run, sized mostly to fit; now and then oversized or cut short
          room = int'(eff_capacity()) - int'(stack_level);
          case ($urandom_range(0, 39))
            0:          n = 0;
            1:          n = $urandom_range(16, 31);
            2, 3, 4, 5: n = $urandom_range(1, 16);
            default:    n = $urandom_range(1, (room > 1) ? room : 1);
          endcase
          sent = (n == 0) ? 1 : n;
          cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, sent) : sent;
          for (int i = 0; i < cut; i++)
            send_request(lbs_pkg::OP_PUSH, (i == 0) ? 5'(n) : 5'($urandom), rand_word());
        end else if (pick < 80) begin
          if (stack_level > 0 && $urandom_range(0, 9) < 8)
            n = $urandom_range(1, stack_level);
          else
            n = $urandom_range(0, 31);
          send_request(lbs_pkg::OP_POP, 5'(n), $urandom);
        end else if (pick < 94) begin
          send_request(lbs_pkg::OP_PEEK, 5'($urandom), $urandom);
        end else begin
          send_request(lbs_pkg::OP_NONE, 5'($urandom), $urandom);
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_stack();
    test_small_capacity();
    test_default_capacity();
    test_shrink_capacity();
    test_abandoned_run();
    test_random_traffic();

    drain();
    repeat (5) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
